>>> src/ipcc_pkg.sv
// Package for the IPv4 frame classifier and checksum checker.
// Holds shared constants, codes, record types and the ones' complement adder.
// No dependencies.
package ipcc_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 16384;
	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [15:0] ETH_ARP  = 16'h0806;
	localparam logic [15:0] ETH_IPV6 = 16'h86DD;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_IGMP = 8'd2;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [1:0] REG_LINK_TYPE    = 2'd0;
	localparam logic [1:0] REG_CHECK_ENABLE = 2'd1;
	localparam logic [1:0] REG_TTL_LIMIT    = 2'd2;
	localparam logic [7:0] TTL_LIMIT_RESET  = 8'd10;

	typedef enum logic [2:0] {
		CLS_UNKNOWN = 3'd0,
		CLS_IPV4    = 3'd1,
		CLS_TCP     = 3'd2,
		CLS_UDP     = 3'd3,
		CLS_ICMP    = 3'd4,
		CLS_IGMP    = 3'd5,
		CLS_ARP     = 3'd6,
		CLS_IPV6    = 3'd7
	} pkt_class_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_IP   = 3'd1,
		ERR_TCP  = 3'd2,
		ERR_UDP  = 3'd3,
		ERR_ICMP = 3'd4,
		ERR_TTL  = 3'd5
	} err_code_t;

	typedef struct packed {
		logic       link_type;
		logic       check_enable;
		logic [7:0] ttl_limit;
	} cfg_t;

	// Everything the back end needs about one finished frame.
	typedef struct packed {
		logic [CNT_W-1:0] n_bytes;
		logic [15:0]      ether_kind;
		logic [3:0]       ip_header_words;
		logic [7:0]       ip_proto;
		logic [7:0]       ip_ttl;
		logic [3:0]       tcp_offset_words;
		logic [15:0]      udp_total_len;
		logic [15:0]      ip_accum;
		logic [15:0]      l4_accum;
		logic [15:0]      ip_field_sum;
		logic [15:0]      l4_field_sum;
	} frame_rec_t;

	// Ones' complement add with end-around carry.
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			if (s > 17'h0FFFF) begin
				s = s - 17'h0FFFF;
			end
			oc_add = s[15:0];
		end
	endfunction

endpackage

>>> src/ipcc_if.sv
// Channel interfaces for frame bytes in and classification results out.
// Depends on nothing.
interface ipcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipcc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  packet_class;
	logic        parsed_ok;
	logic        malformed;
	logic [2:0]  error_code;
	logic [14:0] payload_offset;
	logic [14:0] payload_length;
	logic [5:0]  options_length;
	modport source (output valid, output packet_class, output parsed_ok, output malformed,
		output error_code, output payload_offset, output payload_length,
		output options_length, input ready);
	modport sink (input valid, input packet_class, input parsed_ok, input malformed,
		input error_code, input payload_offset, input payload_length,
		input options_length, output ready);
endinterface

>>> src/ipcc_front.sv
// Front end: takes frame bytes, keeps per-frame parse state and running sums,
// and pushes one frame record into the queue on the last byte. Uses ipcc_pkg.
module ipcc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               link_type,
	ipcc_byte_if.sink          frame,
	input  logic               q_full,
	output logic               q_push,
	output ipcc_pkg::frame_rec_t rec
);
	import ipcc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	frame_rec_t       st_q, st_d;
	logic             take, ipon, accept;
	logic [CNT_W-1:0] hdr, p, q;
	logic [15:0]      val;
	logic [5:0]       hl;
	logic [15:0]      ek;
	logic [CNT_W-1:0] n_next;

	assign frame.ready = !q_full;
	assign accept = frame.valid && frame.ready;
	assign q_push = accept && frame.last_byte;

	// Per-byte update of header fields and checksum accumulators.
	always_comb begin
		st_d = st_q;
		hdr = link_type ? CNT_W'(16) : CNT_W'(14);
		take = cnt_q < CNT_W'(MAX_FRAME_BYTES);
		ek = st_q.ether_kind;
		if (take && (cnt_q == hdr - CNT_W'(2) || cnt_q == hdr - CNT_W'(1))) begin
			ek = {st_q.ether_kind[7:0], frame.data_byte};
		end
		st_d.ether_kind = ek;
		ipon = take && (cnt_q >= hdr) && (ek == ETH_IPV4);
		p = cnt_q - hdr;
		val = p[0] ? {8'h00, frame.data_byte} : {frame.data_byte, 8'h00};
		hl = 6'd0;
		q = '0;
		if (ipon) begin
			if (p == CNT_W'(0)) st_d.ip_header_words = frame.data_byte[3:0];
			if (p == CNT_W'(8)) st_d.ip_ttl = frame.data_byte;
			if (p == CNT_W'(9)) st_d.ip_proto = frame.data_byte;
			hl = (st_d.ip_header_words < 4'd5) ? 6'd20 : {st_d.ip_header_words, 2'b00};
			if (p < CNT_W'(hl)) begin
				if (p == CNT_W'(10) || p == CNT_W'(11)) begin
					st_d.ip_field_sum = {st_q.ip_field_sum[7:0], frame.data_byte};
				end else begin
					st_d.ip_accum = oc_add(st_q.ip_accum, val);
				end
				if (p >= CNT_W'(12) && p < CNT_W'(20)
					&& (st_d.ip_proto == PROTO_TCP || st_d.ip_proto == PROTO_UDP)) begin
					st_d.l4_accum = oc_add(st_q.l4_accum, val);
				end
			end else begin
				q = p - CNT_W'(hl);
				case (st_d.ip_proto)
					PROTO_TCP: begin
						if (q == CNT_W'(12)) st_d.tcp_offset_words = frame.data_byte[7:4];
						if (q == CNT_W'(16) || q == CNT_W'(17)) begin
							st_d.l4_field_sum = {st_q.l4_field_sum[7:0], frame.data_byte};
						end else begin
							st_d.l4_accum = oc_add(st_q.l4_accum, val);
						end
					end
					PROTO_UDP: begin
						if (q == CNT_W'(4) || q == CNT_W'(5)) begin
							st_d.udp_total_len = {st_q.udp_total_len[7:0], frame.data_byte};
						end
						if (q < CNT_W'(8) || {1'b0, q} < 16'(st_d.udp_total_len)
							|| 16'(q) < st_d.udp_total_len) begin
							if (q == CNT_W'(6) || q == CNT_W'(7)) begin
								st_d.l4_field_sum = {st_q.l4_field_sum[7:0], frame.data_byte};
							end else begin
								st_d.l4_accum = oc_add(st_q.l4_accum, val);
							end
						end
					end
					PROTO_ICMP: begin
						if (q == CNT_W'(2) || q == CNT_W'(3)) begin
							st_d.l4_field_sum = {st_q.l4_field_sum[7:0], frame.data_byte};
						end else begin
							st_d.l4_accum = oc_add(st_q.l4_accum, val);
						end
					end
					default: begin
					end
				endcase
			end
		end
		n_next = take ? cnt_q + CNT_W'(1) : cnt_q;
		st_d.n_bytes = n_next;
	end

	assign rec = st_d;

	// Frame state registers; cleared after the last beat of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			st_q <= '0;
		end else if (accept) begin
			if (frame.last_byte) begin
				cnt_q <= '0;
				st_q <= '0;
			end else begin
				cnt_q <= n_next;
				st_q <= st_d;
			end
		end
	end

endmodule

>>> src/ipcc_fifo.sv
// Short queue of frame records between front and back end.
// Uses ipcc_pkg for the record type and depth.
module ipcc_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ipcc_pkg::frame_rec_t wr_rec,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output ipcc_pkg::frame_rec_t rd_rec
);
	import ipcc_pkg::*;

	frame_rec_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_rec = mem_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wr_rec;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + QPTR_W'(1);
			if (do_pop) rp_q <= rp_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count over depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("push did not grow queue");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
		else $error("pop did not shrink queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == QPTR_W'(rp_q + QPTR_W'(cnt_q))) else $error("pointers disagree with count");

endmodule

>>> src/ipcc_back.sv
// Back end: finishes the pseudo-header sums, classifies, runs the checks and
// holds the result in an output register. Uses ipcc_pkg and ipcc_result_if.
module ipcc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ipcc_pkg::cfg_t       cfg,
	input  ipcc_pkg::frame_rec_t rec,
	input  logic                 q_empty,
	output logic                 q_pop,
	ipcc_result_if.source        result
);
	import ipcc_pkg::*;

	logic             out_valid_q;
	pkt_class_t       cls;
	err_code_t        err, l4_err;
	logic             ok, l4_chk;
	logic [CNT_W-1:0] hdr, l4s, rest, poff, plen;
	logic [5:0]       hl, th, olen;
	logic [15:0]      acc, span;

	assign q_pop = !q_empty && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;

	// Classification and checksum decision for one frame record.
	always_comb begin
		cls = CLS_UNKNOWN;
		ok = 1'b0;
		err = ERR_NONE;
		l4_err = ERR_NONE;
		l4_chk = 1'b0;
		poff = '0;
		plen = '0;
		olen = '0;
		acc = rec.l4_accum;
		span = '0;
		hdr = cfg.link_type ? CNT_W'(16) : CNT_W'(14);
		hl = (rec.ip_header_words < 4'd5) ? 6'd20 : {rec.ip_header_words, 2'b00};
		th = (rec.tcp_offset_words < 4'd5) ? 6'd20 : {rec.tcp_offset_words, 2'b00};
		l4s = hdr + CNT_W'(hl);
		rest = (rec.n_bytes > l4s) ? rec.n_bytes - l4s : '0;
		if (rec.n_bytes >= hdr) begin
			if (rec.ether_kind == ETH_IPV4) begin
				ok = 1'b1;
				case (rec.ip_proto)
					PROTO_TCP: begin
						cls = CLS_TCP;
						l4_err = ERR_TCP;
						l4_chk = 1'b1;
						olen = th - 6'd20;
						poff = l4s + CNT_W'(th);
						plen = (rec.n_bytes > poff) ? rec.n_bytes - poff : '0;
						span = (rest > CNT_W'(th)) ? 16'(rest) : 16'(th);
						acc = oc_add(oc_add(rec.l4_accum, 16'(PROTO_TCP)), span);
					end
					PROTO_UDP: begin
						cls = CLS_UDP;
						l4_err = ERR_UDP;
						l4_chk = 1'b1;
						poff = l4s + CNT_W'(8);
						plen = (rec.udp_total_len > 16'd8) ?
							CNT_W'(rec.udp_total_len - 16'd8) : '0;
						span = (rec.udp_total_len < 16'd8) ? 16'd8 : rec.udp_total_len;
						acc = oc_add(oc_add(rec.l4_accum, 16'(PROTO_UDP)), span);
					end
					PROTO_ICMP: begin
						cls = CLS_ICMP;
						l4_err = ERR_ICMP;
						l4_chk = 1'b1;
						poff = l4s + CNT_W'(8);
						plen = (rest > CNT_W'(8)) ? rest - CNT_W'(8) : '0;
					end
					PROTO_IGMP: cls = CLS_IGMP;
					default: cls = CLS_IPV4;
				endcase
				if (cfg.check_enable) begin
					if (~rec.ip_accum != rec.ip_field_sum) begin
						err = ERR_IP;
					end else if (l4_chk && ~acc != rec.l4_field_sum) begin
						err = l4_err;
					end
					if (rec.ip_ttl <= cfg.ttl_limit) err = ERR_TTL;
				end
			end else if (rec.ether_kind == ETH_ARP) begin
				cls = CLS_ARP;
				ok = 1'b1;
			end else if (rec.ether_kind == ETH_IPV6) begin
				cls = CLS_IPV6;
				ok = 1'b1;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			result.packet_class <= cls;
			result.parsed_ok <= ok;
			result.malformed <= err != ERR_NONE;
			result.error_code <= err;
			result.payload_offset <= 15'(poff);
			result.payload_length <= 15'(plen);
			result.options_length <= olen;
		end
	end

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q) else $error("popped record not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !q_pop) else $error("stalled result overwritten");
	a_mal_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result.error_code != ERR_NONE |-> result.parsed_ok)
		else $error("error on unparsed frame");

endmodule

>>> src/ipv4_packet_classify_checksum_check_core.sv
// IPv4 frame classifier and checksum checker, top level.
// Depends on ipcc_pkg, ipcc_if, ipcc_front, ipcc_fifo and ipcc_back.
//
// Frame bytes enter one per beat on frame, in wire order, and the beat with
// last_byte high yields one result on result; other beats yield none. The
// block takes one byte per clock while the queue has room: the front end folds
// each byte into its running ones' complement sums in that cycle, and at the
// last byte hands a frame record to a four-entry queue. The back end works out
// each record combinationally as it leaves the queue and captures the result in
// an output register, from which result valid comes, and the front end keeps
// taking bytes while results wait. Input stalls, for any byte, while all four
// queue entries hold finished frames, which happens only when the result side
// has fallen behind. Configuration registers (link_type,
// check_enable, ttl_limit at indexes 0 to 2) are written through cfg_we,
// cfg_index and cfg_wdata and should change only between frames.
module ipv4_packet_classify_checksum_check_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_wdata,
	ipcc_byte_if.sink     frame,
	ipcc_result_if.source result
);
	import ipcc_pkg::*;

	cfg_t       cfg_q;
	frame_rec_t wr_rec, rd_rec;
	logic       q_push, q_pop, q_full, q_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_type <= 1'b0;
			cfg_q.check_enable <= 1'b0;
			cfg_q.ttl_limit <= TTL_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINK_TYPE: cfg_q.link_type <= cfg_wdata[0];
				REG_CHECK_ENABLE: cfg_q.check_enable <= cfg_wdata[0];
				REG_TTL_LIMIT: cfg_q.ttl_limit <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ipcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.link_type (cfg_q.link_type),
		.frame     (frame),
		.q_full    (q_full),
		.q_push    (q_push),
		.rec       (wr_rec)
	);

	ipcc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_rec (wr_rec),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rd_rec (rd_rec)
	);

	ipcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rec     (rd_rec),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

>>> tb/ipv4_packet_classify_checksum_check_core_test.sv
// Self-checking testbench for the IPv4 frame classifier and checksum checker.
// Uses ipcc_pkg, the ipcc_byte_if and ipcc_result_if channel interfaces and
// the core itself.
module ipv4_packet_classify_checksum_check_core_test;
	import ipcc_pkg::*;

	typedef struct {
		pkt_class_t cls;
		bit         ok;
		bit         mal;
		err_code_t  err;
		bit [14:0]  poff;
		bit [14:0]  plen;
		bit [5:0]   olen;
	} verdict_t;

	typedef struct {
		bit [15:0] etype;
		bit [7:0]  proto;
		bit [3:0]  ihl;
		bit [7:0]  ttl;
		bit [3:0]  toff;
		int        body;
		bit [15:0] ulen;
		bit        good;
		int        cut;
	} frame_spec_t;

	typedef struct {
		bit          lt;
		bit          chk;
		bit [7:0]    lim;
		frame_spec_t f;
		bit          typed;
		verdict_t    want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	ipcc_byte_if   frame_ch();
	ipcc_result_if res_ch();

	ipv4_packet_classify_checksum_check_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.frame(frame_ch),
		.result(res_ch)
	);

	// Verdicts expected from the block, oldest first.
	verdict_t pending_verdicts[$];
	int       fail_count = 0;
	int       bytes_sent = 0;
	bit       quiet = 0;
	bit       long_hold_req = 0;
	bit       use_typed = 0;
	verdict_t typed_verdict;
	bit [7:0] wire_bytes[$];
	dir_row_t rows[16];

	// Shadow of the configuration and of the per-frame parse state.
	bit        sh_link, sh_chk;
	bit [7:0]  sh_ttl_lim;
	bit [14:0] sh_cnt;
	bit [15:0] sh_kind, sh_udp_len, sh_ip_acc, sh_l4_acc, sh_ip_fs, sh_l4_fs;
	bit [3:0]  sh_ihw, sh_tcpw;
	bit [7:0]  sh_proto, sh_ttl;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit [15:0] ones_add(input bit [15:0] a, input bit [15:0] b);
		bit [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > 17'h0FFFF) begin
			s = s - 17'h0FFFF;
		end
		return s[15:0];
	endfunction

	// A byte at an even offset in its region is the high half of a word.
	function automatic bit [15:0] weigh(input int k, input bit [7:0] b);
		return (k % 2) ? {8'h00, b} : {b, 8'h00};
	endfunction

	function automatic int link_bytes();
		return sh_link ? 16 : 14;
	endfunction

	function automatic int ip_hdr_bytes();
		return ((sh_ihw < 5) ? 5 : sh_ihw) * 4;
	endfunction

	function automatic void clear_parse();
		sh_cnt = '0; sh_kind = '0; sh_ihw = '0; sh_proto = '0; sh_ttl = '0;
		sh_tcpw = '0; sh_udp_len = '0; sh_ip_acc = '0; sh_l4_acc = '0;
		sh_ip_fs = '0; sh_l4_fs = '0;
	endfunction

	// Fold one frame byte into the running header fields and sums.
	function automatic void fold_byte(input bit [7:0] b);
		int i, hdr, p, q, hl;
		bit [15:0] val;
		i = sh_cnt;
		hdr = link_bytes();
		if (i == hdr - 2 || i == hdr - 1) begin
			sh_kind = {sh_kind[7:0], b};
		end
		if (i < hdr || sh_kind != ETH_IPV4) begin
			return;
		end
		p = i - hdr;
		val = weigh(p, b);
		if (p == 0) sh_ihw = b[3:0];
		if (p == 8) sh_ttl = b;
		if (p == 9) sh_proto = b;
		hl = ip_hdr_bytes();
		if (p < hl) begin
			if (p == 10 || p == 11) sh_ip_fs = {sh_ip_fs[7:0], b};
			else sh_ip_acc = ones_add(sh_ip_acc, val);
			if (p >= 12 && p < 20 && (sh_proto == PROTO_TCP || sh_proto == PROTO_UDP)) begin
				sh_l4_acc = ones_add(sh_l4_acc, val);
			end
			return;
		end
		q = p - hl;
		if (sh_proto == PROTO_TCP) begin
			if (q == 12) sh_tcpw = b[7:4];
			if (q == 16 || q == 17) sh_l4_fs = {sh_l4_fs[7:0], b};
			else sh_l4_acc = ones_add(sh_l4_acc, val);
		end else if (sh_proto == PROTO_UDP) begin
			if (q == 4 || q == 5) sh_udp_len = {sh_udp_len[7:0], b};
			if (q < 8 || q < int'(sh_udp_len)) begin
				if (q == 6 || q == 7) sh_l4_fs = {sh_l4_fs[7:0], b};
				else sh_l4_acc = ones_add(sh_l4_acc, val);
			end
		end else if (sh_proto == PROTO_ICMP) begin
			if (q == 2 || q == 3) sh_l4_fs = {sh_l4_fs[7:0], b};
			else sh_l4_acc = ones_add(sh_l4_acc, val);
		end
	endfunction

	// Classify the finished frame and run the enabled checks.
	function automatic verdict_t classify_frame();
		verdict_t v;
		int n, hdr, hl, l4s, rest, th, poff, plen;
		bit [15:0] acc;
		bit l4_checked;
		v = '{CLS_UNKNOWN, 1'b0, 1'b0, ERR_NONE, '0, '0, '0};
		n = sh_cnt;
		hdr = link_bytes();
		if (n < hdr) begin
			return v;
		end
		if (sh_kind == ETH_IPV4) begin
			hl = ip_hdr_bytes();
			l4s = hdr + hl;
			rest = (n > l4s) ? n - l4s : 0;
			acc = sh_l4_acc;
			l4_checked = 1'b1;
			poff = 0;
			plen = 0;
			v.ok = 1'b1;
			if (sh_proto == PROTO_TCP) begin
				th = ((sh_tcpw < 5) ? 5 : sh_tcpw) * 4;
				v.cls = CLS_TCP;
				v.olen = 6'(th - 20);
				poff = l4s + th;
				plen = (n > poff) ? n - poff : 0;
				acc = ones_add(acc, 16'd6);
				acc = ones_add(acc, 16'((rest > th) ? rest : th));
			end else if (sh_proto == PROTO_UDP) begin
				v.cls = CLS_UDP;
				poff = l4s + 8;
				plen = (sh_udp_len > 8) ? sh_udp_len - 8 : 0;
				acc = ones_add(acc, 16'd17);
				acc = ones_add(acc, (sh_udp_len < 8) ? 16'd8 : sh_udp_len);
			end else if (sh_proto == PROTO_ICMP) begin
				v.cls = CLS_ICMP;
				poff = l4s + 8;
				plen = (rest > 8) ? rest - 8 : 0;
			end else begin
				v.cls = (sh_proto == PROTO_IGMP) ? CLS_IGMP : CLS_IPV4;
				l4_checked = 1'b0;
			end
			v.poff = 15'(poff);
			v.plen = 15'(plen);
			if (sh_chk) begin
				if (~sh_ip_acc != sh_ip_fs) begin
					v.err = ERR_IP;
				end else if (l4_checked && ~acc != sh_l4_fs) begin
					case (v.cls)
						CLS_TCP: v.err = ERR_TCP;
						CLS_UDP: v.err = ERR_UDP;
						default: v.err = ERR_ICMP;
					endcase
				end
				if (sh_ttl <= sh_ttl_lim) v.err = ERR_TTL;
			end
			v.mal = (v.err != ERR_NONE);
		end else if (sh_kind == ETH_ARP) begin
			v.cls = CLS_ARP;
			v.ok = 1'b1;
		end else if (sh_kind == ETH_IPV6) begin
			v.cls = CLS_IPV6;
			v.ok = 1'b1;
		end
		return v;
	endfunction

	// Called for every accepted input beat.
	function automatic void take_beat(input bit [7:0] b, input bit last);
		verdict_t v;
		if (sh_cnt < MAX_FRAME_BYTES) begin
			fold_byte(b);
			sh_cnt = sh_cnt + 1'b1;
		end
		if (last) begin
			v = classify_frame();
			pending_verdicts.push_back(use_typed ? typed_verdict : v);
			clear_parse();
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	// Build a frame in wire_bytes, with valid checksums when asked.
	function automatic void build_frame(input frame_spec_t f);
		int hdr, hl, s, l, th, ext, lim;
		bit [15:0] sum, pseudo;
		wire_bytes.delete();
		hdr = link_bytes();
		for (int k = 0; k < hdr - 2; k++) wire_bytes.push_back(8'($urandom));
		wire_bytes.push_back(f.etype[15:8]);
		wire_bytes.push_back(f.etype[7:0]);
		if (f.etype != ETH_IPV4) begin
			for (int k = 0; k < f.body; k++) wire_bytes.push_back(8'($urandom));
		end else begin
			s = hdr;
			hl = ((f.ihl < 5) ? 5 : f.ihl) * 4;
			for (int k = 0; k < hl + f.body; k++) wire_bytes.push_back(8'($urandom));
			wire_bytes[s] = {4'h4, f.ihl};
			wire_bytes[s + 8] = f.ttl;
			wire_bytes[s + 9] = f.proto;
			wire_bytes[s + 10] = 8'h00;
			wire_bytes[s + 11] = 8'h00;
			l = s + hl;
			if (f.proto == PROTO_TCP) begin
				if (f.body > 12) wire_bytes[l + 12] = {f.toff, 4'($urandom)};
				if (f.body > 17) begin
					wire_bytes[l + 16] = 8'h00;
					wire_bytes[l + 17] = 8'h00;
				end
			end else if (f.proto == PROTO_UDP && f.body > 7) begin
				wire_bytes[l + 4] = f.ulen[15:8];
				wire_bytes[l + 5] = f.ulen[7:0];
				wire_bytes[l + 6] = 8'h00;
				wire_bytes[l + 7] = 8'h00;
			end else if (f.proto == PROTO_ICMP && f.body > 3) begin
				wire_bytes[l + 2] = 8'h00;
				wire_bytes[l + 3] = 8'h00;
			end
			if (f.good) begin
				// Header checksum over the whole IHL extent.
				sum = '0;
				for (int p = 0; p < hl; p++) begin
					if (p != 10 && p != 11) sum = ones_add(sum, weigh(p, wire_bytes[s + p]));
				end
				wire_bytes[s + 10] = ~sum[15:8];
				wire_bytes[s + 11] = ~sum[7:0];
				// Pseudo-header addresses are shared by TCP and UDP.
				pseudo = '0;
				for (int p = 12; p < 20; p++) pseudo = ones_add(pseudo, weigh(p, wire_bytes[s + p]));
				if (f.proto == PROTO_TCP && f.body > 17) begin
					th = ((wire_bytes[l + 12][7:4] < 5) ? 5 : wire_bytes[l + 12][7:4]) * 4;
					sum = ones_add(ones_add(pseudo, 16'd6), 16'((f.body > th) ? f.body : th));
					for (int q = 0; q < f.body; q++) begin
						if (q != 16 && q != 17) sum = ones_add(sum, weigh(q, wire_bytes[l + q]));
					end
					wire_bytes[l + 16] = ~sum[15:8];
					wire_bytes[l + 17] = ~sum[7:0];
				end else if (f.proto == PROTO_UDP && f.body > 7) begin
					ext = (f.ulen < 8) ? 8 : f.ulen;
					lim = (ext < f.body) ? ext : f.body;
					sum = ones_add(ones_add(pseudo, 16'd17), 16'(ext));
					for (int q = 0; q < lim; q++) begin
						if (q != 6 && q != 7) sum = ones_add(sum, weigh(q, wire_bytes[l + q]));
					end
					wire_bytes[l + 6] = ~sum[15:8];
					wire_bytes[l + 7] = ~sum[7:0];
				end else if (f.proto == PROTO_ICMP && f.body > 3) begin
					sum = '0;
					for (int q = 0; q < f.body; q++) begin
						if (q != 2 && q != 3) sum = ones_add(sum, weigh(q, wire_bytes[l + q]));
					end
					wire_bytes[l + 2] = ~sum[15:8];
					wire_bytes[l + 3] = ~sum[7:0];
				end
			end
		end
		if (f.cut > 0) begin
			while (wire_bytes.size() > f.cut) void'(wire_bytes.pop_back());
		end
	endfunction

	// Offer one beat, with an occasional idle burst in front of it.
	task automatic send_beat(input bit [7:0] b, input bit last);
		int gap;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 19);
			frame_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data_byte <= b;
		frame_ch.last_byte <= last;
		do @(posedge clk); while (!frame_ch.ready);
		take_beat(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_spec_t f, input bit corrupt);
		int k;
		build_frame(f);
		if (corrupt) begin
			k = $urandom_range(0, wire_bytes.size() - 1);
			wire_bytes[k] = wire_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (wire_bytes[i]) send_beat(wire_bytes[i], i == wire_bytes.size() - 1);
	endtask

	// Stop offering and wait until every verdict has come back.
	task automatic drain();
		frame_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write all three registers back to back while the block is idle.
	task automatic set_config(input bit lt, input bit chk, input bit [7:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_LINK_TYPE;
		cfg_wdata <= {7'd0, lt};
		@(negedge clk);
		cfg_index <= REG_CHECK_ENABLE;
		cfg_wdata <= {7'd0, chk};
		@(negedge clk);
		cfg_index <= REG_TTL_LIMIT;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_link = lt;
		sh_chk = chk;
		sh_ttl_lim = lim;
	endtask

	function automatic frame_spec_t random_spec();
		frame_spec_t f;
		int r, th, n;
		r = $urandom_range(0, 99);
		f.etype = (r < 72) ? ETH_IPV4 : (r < 82) ? ETH_ARP : (r < 88) ? ETH_IPV6 : 16'($urandom);
		r = $urandom_range(0, 9);
		f.proto = (r < 3) ? PROTO_TCP : (r < 6) ? PROTO_UDP : (r < 8) ? PROTO_ICMP :
			(r < 9) ? PROTO_IGMP : 8'($urandom);
		f.ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7));
		f.toff = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8));
		f.ttl = 8'($urandom);
		th = ((f.toff < 5) ? 5 : f.toff) * 4;
		n = $urandom_range(0, 40);
		f.body = (f.proto == PROTO_TCP) ? th + n : 8 + n;
		r = $urandom_range(0, 9);
		f.ulen = (r < 7) ? 16'(f.body) : (r < 9) ? 16'($urandom_range(0, 60)) : 16'($urandom);
		f.good = ($urandom_range(0, 9) != 0);
		f.cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 80) : 0;
		return f;
	endfunction

	// Result side: random stall bursts, plus one long hold on request.
	always begin
		@(negedge clk);
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			res_ch.ready <= 1'b0;
			repeat (300) @(negedge clk);
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			res_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		res_ch.ready <= 1'b1;
	end

	// Compare each result beat with the oldest expected verdict.
	always @(posedge clk) begin
		verdict_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result beats outstanding", 1, 0);
			end else begin
				w = pending_verdicts.pop_front();
				if (res_ch.packet_class !== w.cls)
					report_mismatch("packet_class", res_ch.packet_class, w.cls);
				if (res_ch.parsed_ok !== w.ok)
					report_mismatch("parsed_ok", res_ch.parsed_ok, w.ok);
				if (res_ch.malformed !== w.mal)
					report_mismatch("malformed", res_ch.malformed, w.mal);
				if (res_ch.error_code !== w.err)
					report_mismatch("error_code", res_ch.error_code, w.err);
				if (res_ch.payload_offset !== w.poff)
					report_mismatch("payload_offset", res_ch.payload_offset, w.poff);
				if (res_ch.payload_length !== w.plen)
					report_mismatch("payload_length", res_ch.payload_length, w.plen);
				if (res_ch.options_length !== w.olen)
					report_mismatch("options_length", res_ch.options_length, w.olen);
			end
		end
	end

	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		verdict_t none;
		frame_spec_t f;
		int frames;
		none = '{CLS_UNKNOWN, 1'b0, 1'b0, ERR_NONE, '0, '0, '0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LINK_TYPE;
		cfg_wdata = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data_byte = '0;
		frame_ch.last_byte = 1'b0;
		res_ch.ready = 1'b1;
		sh_link = 1'b0;
		sh_chk = 1'b0;
		sh_ttl_lim = TTL_LIMIT_RESET;
		clear_parse();

		// Directed frames: class extremes, every protocol and the corner cases.
		rows[0] = '{0, 0, 8'd10, '{ETH_ARP, 0, 5, 64, 5, 28, 0, 1, 0}, 1,
			'{CLS_ARP, 1, 0, ERR_NONE, 0, 0, 0}};
		rows[1] = '{1, 0, 8'd10, '{ETH_IPV6, 0, 5, 64, 5, 40, 0, 1, 0}, 1,
			'{CLS_IPV6, 1, 0, ERR_NONE, 0, 0, 0}};
		rows[2] = '{0, 1, 8'd10, '{16'h1234, 0, 5, 64, 5, 20, 0, 1, 0}, 1, none};
		rows[3] = '{0, 1, 8'd10, '{ETH_IPV4, PROTO_TCP, 5, 64, 5, 30, 0, 1, 7}, 1, none};
		rows[4] = '{1, 1, 8'd10, '{ETH_IPV4, PROTO_IGMP, 5, 3, 5, 8, 0, 1, 0}, 1,
			'{CLS_IGMP, 1, 1, ERR_TTL, 0, 0, 0}};
		rows[5] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_TCP, 5, 64, 5, 30, 0, 1, 0}, 0, none};
		rows[6] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_TCP, 5, 64, 15, 70, 0, 1, 0}, 0, none};
		rows[7] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_TCP, 15, 64, 2, 25, 0, 1, 0}, 0, none};
		rows[8] = '{1, 1, 8'd255, '{ETH_IPV4, PROTO_UDP, 5, 255, 5, 20, 20, 1, 0}, 0, none};
		rows[9] = '{1, 1, 8'd0, '{ETH_IPV4, PROTO_UDP, 5, 1, 5, 12, 0, 1, 0}, 0, none};
		rows[10] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_UDP, 5, 9, 5, 10, 16'hFFFF, 1, 0}, 0, none};
		rows[11] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_ICMP, 5, 128, 5, 40, 0, 1, 0}, 0, none};
		rows[12] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_ICMP, 6, 128, 5, 40, 0, 0, 0}, 0, none};
		rows[13] = '{0, 1, 8'd0, '{ETH_IPV4, 8'd99, 0, 0, 5, 6, 0, 1, 0}, 0, none};
		rows[14] = '{0, 1, 8'd0, '{ETH_IPV4, PROTO_TCP, 5, 64, 5, 40, 0, 1, 45}, 0, none};
		rows[15] = '{0, 0, 8'd10, '{ETH_IPV4, 8'd99, 5, 64, 5, 100, 0, 1, 0}, 1,
			'{CLS_IPV4, 1, 0, ERR_NONE, 0, 0, 0}};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			drain();
			set_config(rows[i].lt, rows[i].chk, rows[i].lim);
			use_typed = rows[i].typed;
			typed_verdict = rows[i].want;
			send_frame(rows[i].f, 1'b0);
		end
		use_typed = 1'b0;

		// Random frames, with a new setting every so often.
		frames = 0;
		while (bytes_sent < 2000) begin
			if (frames % 4 == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: set_config(1'b0, 1'b1, 8'd0);
					1: set_config(1'b1, 1'b1, 8'd255);
					default: set_config(1'($urandom), ($urandom_range(0, 3) != 0),
						8'($urandom_range(0, 40)));
				endcase
			end
			if (frames == 3) begin
				// Hold the result side off while short frames pile up.
				long_hold_req = 1'b1;
				f = '{ETH_ARP, 0, 5, 64, 5, 0, 0, 1, 0};
				repeat (10) send_frame(f, 1'b0);
			end
			if (bytes_sent > 1700) quiet = 1'b1;
			send_frame(random_spec(), $urandom_range(0, 9) == 0);
			frames++;
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
